// ===== hw/rtl/gjc_pkg.sv =====
// Shared widths, constants, stage types and Gaussian table functions of the gap junction unit.
package gjc_pkg;

   localparam int VOLT_W   = 16;
   localparam int WEIGHT_W = 16;
   localparam int NODE_W   = 12;
   localparam int SCALE_W  = 16;
   localparam int DELTA_W  = 40;
   localparam int DIFF_W   = VOLT_W + 1;
   localparam int MAG_W    = VOLT_W;
   localparam int IDX_W    = MAG_W - 4;
   localparam int GAUSS_W  = 17;
   localparam int NUM_W    = GAUSS_W + 2;
   localparam int WA_W     = WEIGHT_W + MAG_W;
   localparam int PROD_W   = 51;
   localparam int LO_W     = 26;
   localparam int PH_W     = PROD_W - LO_W + SCALE_W;
   localparam int PL_W     = LO_W + SCALE_W;
   localparam int SUM_W    = PROD_W + SCALE_W;
   localparam int RSH_W    = 28;
   localparam int P1_W     = SUM_W - RSH_W;
   localparam int Q_W      = DELTA_W;

   localparam int STAGES = 9;

   localparam int GAUSS_ENTRIES_DEF = 1024;
   localparam int GAUSS_NONZERO     = 555;
   localparam int BANK_MAX          = 256;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1000;

   localparam longint unsigned ONE_Q30 = 64'd1 << 30;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              last;
      logic              pos;
   } side_type;

   function automatic longint unsigned div_u64(input longint unsigned num,
                                               input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      int              b;
      quo = 64'd0;
      rem = 64'd0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         quo = {quo[62:0], 1'b0};
         if (rem >= den) begin
            rem    = rem - den;
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic longint unsigned exp_neg_q30(input longint unsigned f);
      longint unsigned term;
      longint          total;
      longint unsigned i;
      term  = ONE_Q30;
      total = longint'(ONE_Q30);
      for (i = 1; i <= 20; i++) begin
         term = div_u64((term * f) >> 30, i);
         if (i[0]) begin
            total = total - longint'(term);
         end else begin
            total = total + longint'(term);
         end
      end
      return (total < 0) ? 64'd0 : longint'(total);
   endfunction

   function automatic logic [GAUSS_W-1:0] gauss_entry(input int k);
      longint unsigned kk;
      longint unsigned x;
      longint unsigned n;
      longint unsigned v;
      longint unsigned e1;
      longint unsigned g;
      int              j;
      kk = longint'(k);
      x  = div_u64(kk * kk * ONE_Q30, 64'd25600);
      n  = x >> 30;
      if (n >= 12) begin
         return '0;
      end
      e1 = exp_neg_q30(ONE_Q30);
      v  = exp_neg_q30(x & (ONE_Q30 - 1));
      for (j = 0; j < 12; j++) begin
         if (longint'(j) < n) begin
            v = (v * e1 + (ONE_Q30 >> 1)) >> 30;
         end
      end
      g = (v + 64'd8192) >> 14;
      if (g > 64'd65536) begin
         g = 64'd65536;
      end
      return g[GAUSS_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/gjc_req_if.sv =====
// Request channel carrying one gap junction per transfer.
interface gjc_req_if import gjc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [VOLT_W-1:0]   v_near;
   logic signed [VOLT_W-1:0]   v_far;
   logic        [WEIGHT_W-1:0] weight;
   logic        [NODE_W-1:0]   node;
   logic                       last_junction;

   modport source (output valid, v_near, v_far, weight, node, last_junction, input ready);
   modport sink   (input valid, v_near, v_far, weight, node, last_junction, output ready);
endinterface

// ===== hw/rtl/gjc_rsp_if.sv =====
// Response channel carrying the current update for one node.
interface gjc_rsp_if import gjc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic        [NODE_W-1:0]  target_node;
   logic signed [DELTA_W-1:0] current_delta;
   logic                      clipped;
   logic                      end_of_batch;

   modport source (output valid, target_node, current_delta, clipped, end_of_batch,
                   input ready);
   modport sink   (input valid, target_node, current_delta, clipped, end_of_batch,
                   output ready);
endinterface

// ===== hw/rtl/gjc_csr_if.sv =====
// Register write channel for the current scale.
interface gjc_csr_if import gjc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SCALE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/gjc_gauss_rom.sv =====
// Banked Gaussian factor table with registered read.
module gjc_gauss_rom import gjc_pkg::*; #(
   parameter int ENTRIES = GAUSS_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               load,
   input  logic [IDX_W-1:0]   idx,
   output logic [GAUSS_W-1:0] gauss
);

   localparam int DEPTH      = (ENTRIES < GAUSS_NONZERO) ? ENTRIES : GAUSS_NONZERO;
   localparam int BANK_DEPTH = (DEPTH < BANK_MAX) ? DEPTH : BANK_MAX;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int BANKS      = (DEPTH + BANK_DEPTH - 1) / BANK_DEPTH;
   localparam int SEL_W      = (BANKS > 1) ? $clog2(BANKS) : 1;

   logic [GAUSS_W-1:0] rom_tbl [BANKS][BANK_DEPTH];
   logic [GAUSS_W-1:0] bank_ff [BANKS];
   logic [SEL_W-1:0]   sel_ff;
   logic [SEL_W-1:0]   sel_in;
   logic               hit_ff;
   logic               hit_in;
   logic [BANK_AW-1:0] addr;

   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      for (genvar e = 0; e < BANK_DEPTH; e++) begin : g_entry
         assign rom_tbl[b][e] = ((b * BANK_DEPTH + e) < DEPTH) ?
                                gauss_entry(b * BANK_DEPTH + e) : '0;
      end
   end

   assign addr   = idx[BANK_AW-1:0];
   assign hit_in = (idx < IDX_W'(DEPTH));
   assign sel_in = SEL_W'(idx >> BANK_AW);

   always_ff @(posedge clock) begin
      if (load) begin
         for (int b = 0; b < BANKS; b++) begin
            bank_ff[b] <= rom_tbl[b][addr];
         end
         sel_ff <= sel_in;
         hit_ff <= hit_in;
      end
   end

   assign gauss = hit_ff ? bank_ff[sel_ff] : '0;

endmodule

// ===== hw/rtl/gjc_mul_pipe.sv =====
// Multiplier stages forming the scaled, rounded junction current times five.
module gjc_mul_pipe import gjc_pkg::*; (
   input  logic                clock,
   input  logic [3:0]          load,
   input  logic [MAG_W-1:0]    mag,
   input  logic [WEIGHT_W-1:0] weight,
   input  logic [GAUSS_W-1:0]  gauss,
   input  logic [SCALE_W-1:0]  scale,
   output logic [P1_W-1:0]     p1
);

   localparam logic [NUM_W-1:0] NUM_ONE    = NUM_W'(1) << 16;
   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(5) << (RSH_W - 1);

   logic [WA_W-1:0]   wa_ff;
   logic [WA_W-1:0]   wa_in;
   logic [NUM_W-1:0]  num_ff;
   logic [NUM_W-1:0]  num_in;
   logic [PROD_W-1:0] a_ff;
   logic [PROD_W-1:0] a_in;
   logic [PH_W-1:0]   ph_ff;
   logic [PH_W-1:0]   ph_in;
   logic [PL_W-1:0]   pl_ff;
   logic [PL_W-1:0]   pl_in;
   logic [SUM_W-1:0]  sum;
   logic [P1_W-1:0]   p1_ff;
   logic [P1_W-1:0]   p1_in;

   assign wa_in  = WA_W'(weight) * WA_W'(mag);
   assign num_in = (NUM_W'(gauss) << 2) + NUM_ONE;
   assign a_in   = PROD_W'(wa_ff) * PROD_W'(num_ff);
   assign ph_in  = PH_W'(a_ff[PROD_W-1:LO_W]) * PH_W'(scale);
   assign pl_in  = PL_W'(a_ff[LO_W-1:0]) * PL_W'(scale);
   assign sum    = {ph_ff, LO_W'(0)} + SUM_W'(pl_ff) + ROUND_HALF;
   assign p1_in  = sum[SUM_W-1:RSH_W];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         wa_ff  <= wa_in;
         num_ff <= num_in;
      end
      if (load[1]) begin
         a_ff <= a_in;
      end
      if (load[2]) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
      end
      if (load[3]) begin
         p1_ff <= p1_in;
      end
   end

   assign p1 = p1_ff;

endmodule

// ===== hw/rtl/gjc_div5.sv =====
// Two-stage division by five using reciprocal multiplication on split halves.
module gjc_div5 import gjc_pkg::*; (
   input  logic            clock,
   input  logic [1:0]      load,
   input  logic [P1_W-1:0] p1,
   output logic [Q_W-1:0]  q
);

   localparam int LO_PART = 20;
   localparam int HI_W    = P1_W - LO_PART;
   localparam int QH_W    = HI_W - 2;
   localparam int K_HI    = 22;
   localparam int M_HI    = ((1 << K_HI) + 1) / 5;
   localparam int HP_W    = HI_W + 20;
   localparam int Y_W     = LO_PART + 3;
   localparam int K_LO    = 26;
   localparam int M_LO    = ((1 << K_LO) + 1) / 5;
   localparam int YP_W    = Y_W + 24;

   logic [HI_W-1:0]    h;
   logic [HP_W-1:0]    hp;
   logic [QH_W-1:0]    qh_in;
   logic [QH_W-1:0]    qh_ff;
   logic [HI_W-1:0]    rem;
   logic [2:0]         rh_in;
   logic [2:0]         rh_ff;
   logic [LO_PART-1:0] l_ff;
   logic [Y_W-1:0]     y;
   logic [YP_W-1:0]    yp;
   logic [Q_W-1:0]     q_in;
   logic [Q_W-1:0]     q_ff;

   assign h     = p1[P1_W-1:LO_PART];
   assign hp    = HP_W'(h) * HP_W'(M_HI);
   assign qh_in = hp[K_HI +: QH_W];
   assign rem   = h - ((HI_W'(qh_in) << 2) + HI_W'(qh_in));
   assign rh_in = rem[2:0];

   assign y    = {rh_ff, l_ff};
   assign yp   = YP_W'(y) * YP_W'(M_LO);
   assign q_in = Q_W'({qh_ff, yp[K_LO +: LO_PART]});

   always_ff @(posedge clock) begin
      if (load[0]) begin
         qh_ff <= qh_in;
         rh_ff <= rh_in;
         l_ff  <= p1[LO_PART-1:0];
      end
      if (load[1]) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

// ===== hw/rtl/gap_junction_current_unit.sv =====
// Top level of the gap junction current pipeline.
//
// One request on req_ch carries a gap junction: near and far membrane
// voltages, a conductance weight, the node index and a batch end mark.
// Each request yields exactly one response on rsp_ch with the node index,
// the signed current update for that node, a saturation flag and the
// batch end mark, in request order.
// The pipeline has nine register stages, and a new request is taken every
// cycle unless a held-low rsp_ch.ready has stalled the full pipeline.
// The stages are the difference, the magnitude with the table read, three
// multiplier stages, the rounding adder, two reciprocal division stages and
// the saturation register.
// When the receiver holds rsp_ch.ready low, the pipeline fills its empty
// stages and then stalls; nothing is lost or repeated.
// The current scale is written over csr_ch, which always accepts, and must
// only change while no request is in flight.
// Reset empties the pipeline and sets the current scale to 1000.
module gap_junction_current_unit import gjc_pkg::*; #(
   parameter int GAUSS_ENTRIES = GAUSS_ENTRIES_DEF
) (
   input logic       clock,
   input logic       reset,
   gjc_req_if.sink   req_ch,
   gjc_rsp_if.source rsp_ch,
   gjc_csr_if.sink   csr_ch
);

   localparam logic [Q_W-1:0] MAX_POS = {1'b0, {(Q_W - 1){1'b1}}};
   localparam logic [Q_W-1:0] MAX_NEG = {1'b1, {(Q_W - 1){1'b0}}};

   logic [SCALE_W-1:0]  scale_ff;
   logic [STAGES-1:0]   load;
   logic [STAGES-1:0]   valid_ff;
   logic [STAGES-1:0]   valid_in;
   side_type            side_ff [STAGES];
   side_type            side_in;

   logic [DIFF_W-1:0]   d_in;
   logic [DIFF_W-1:0]   d_ff;
   logic [WEIGHT_W-1:0] w0_ff;
   logic [DIFF_W-1:0]   ad_in;
   logic [MAG_W-1:0]    mag_in;
   logic [MAG_W-1:0]    mag_ff;
   logic [WEIGHT_W-1:0] w1_ff;
   logic [GAUSS_W-1:0]  gauss;
   logic [P1_W-1:0]     p1;
   logic [Q_W-1:0]      q;
   logic [Q_W-1:0]      delta_in;
   logic [Q_W-1:0]      delta_ff;
   logic                clip_in;
   logic                clip_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_ch.valid) begin
         scale_ff <= csr_ch.data;
      end
   end

   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_ch.ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   assign req_ch.ready = load[0];
   assign valid_in     = {valid_ff[STAGES-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (load & valid_in) | (~load & valid_ff);
      end
   end

   assign d_in         = {req_ch.v_far[VOLT_W-1], req_ch.v_far} -
                         {req_ch.v_near[VOLT_W-1], req_ch.v_near};
   assign side_in.node = req_ch.node;
   assign side_in.last = req_ch.last_junction;
   assign side_in.pos  = !d_in[DIFF_W-1] && (d_in != '0);

   assign ad_in  = d_ff[DIFF_W-1] ? (DIFF_W'(0) - d_ff) : d_ff;
   assign mag_in = ad_in[MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         d_ff       <= d_in;
         w0_ff      <= req_ch.weight;
         side_ff[0] <= side_in;
      end
      if (load[1]) begin
         mag_ff <= mag_in;
         w1_ff  <= w0_ff;
      end
      for (int i = 1; i < STAGES; i++) begin
         if (load[i]) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
      if (load[STAGES-1]) begin
         delta_ff <= delta_in;
         clip_ff  <= clip_in;
      end
   end

   gjc_gauss_rom #(
      .ENTRIES (GAUSS_ENTRIES)
   ) u_rom (
      .clock (clock),
      .load  (load[1]),
      .idx   (mag_in[MAG_W-1:4]),
      .gauss (gauss)
   );

   gjc_mul_pipe u_mul (
      .clock  (clock),
      .load   (load[5:2]),
      .mag    (mag_ff),
      .weight (w1_ff),
      .gauss  (gauss),
      .scale  (scale_ff),
      .p1     (p1)
   );

   gjc_div5 u_div (
      .clock (clock),
      .load  (load[7:6]),
      .p1    (p1),
      .q     (q)
   );

   always_comb begin
      clip_in = 1'b0;
      if (side_ff[STAGES-2].pos) begin
         if (q > MAX_NEG) begin
            clip_in  = 1'b1;
            delta_in = MAX_NEG;
         end else begin
            delta_in = Q_W'(0) - q;
         end
      end else begin
         if (q > MAX_POS) begin
            clip_in  = 1'b1;
            delta_in = MAX_POS;
         end else begin
            delta_in = q;
         end
      end
   end

   assign rsp_ch.valid         = valid_ff[STAGES-1];
   assign rsp_ch.target_node   = side_ff[STAGES-1].node;
   assign rsp_ch.current_delta = delta_ff;
   assign rsp_ch.clipped       = clip_ff;
   assign rsp_ch.end_of_batch  = side_ff[STAGES-1].last;

endmodule
